// ----- rtl/sulf_pkg.sv -----
package sulf_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE   = 2'd2;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [7:0] LINK_NACK   = 8'h02;
    localparam logic [7:0] LINK_SELECT = 8'h43;
    localparam logic [7:0] MSG_CMD     = 8'h40;
    localparam logic [7:0] MSG_DATA    = 8'hc0;
    localparam logic [7:0] EXT_MODE    = 8'h06;
    localparam logic [7:0] MASK_KIND   = 8'hc0;
    localparam logic [7:0] MASK_MODE   = 8'h07;
    localparam logic [7:0] CHECK_SEED  = 8'hff;

    localparam logic [3:0]  MODE_COUNT_RST = 4'd1;
    localparam logic [15:0] HB_LIMIT_RST   = 16'd1000;
    localparam logic [5:0]  EXP_SIZE_RST   = 6'd4;

    // work handed from the front end to the back end, one per accepted item
    typedef struct packed {
        logic       tx;
        logic       has_hdr;
        logic       has_chk;
        logic [7:0] hdr;
        logic [7:0] data;
        logic [7:0] chk;
        logic       rx_valid;
        logic [4:0] rx_idx;
        logic [2:0] mode;
        logic       resync;
    } t_desc;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_frame_end;
        logic       rx_data_valid;
        logic [4:0] rx_data_index;
        logic [7:0] rx_data_value;
        logic [2:0] active_mode;
        logic       resync_request;
        logic       result_last;
    } t_beat;

endpackage

// ----- rtl/sensor_uart_link_framer.sv -----
// Sensor-side link engine for a host-polled UART sensor protocol. Each input beat is a
// received line byte, a transmit payload byte or a time tick, with kind selecting which.
// The front end accepts one input beat per cycle while its four-entry work queue has room,
// parses host messages (NACK, SELECT with checksum, extended-mode command plus data
// message), frames transmit bytes and counts heartbeat ticks. The back end expands each
// queued item into result beats through a registered output stage, one beat per cycle
// while i_ready allows: received bytes and ticks give one beat, a transmit byte one to
// three (header, payload byte, closing checksum). Sustained throughput is therefore one
// item per cycle for receive and tick traffic while i_ready allows, set by the single
// result port of the back end. The user must write configuration through i_cfg_we,
// i_cfg_addr and i_cfg_wdata only while the block is idle; the block does not enforce it.
module sensor_uart_link_framer #(
    parameter int MAX_PAYLOAD = sulf_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = sulf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sulf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sulf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_kind,
    input  logic [7:0]                      i_data_byte,
    input  logic [2:0]                      i_tx_size_code,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_tx_valid,
    output logic [7:0]                      o_tx_byte,
    output logic                            o_tx_frame_end,
    output logic                            o_rx_data_valid,
    output logic [4:0]                      o_rx_data_index,
    output logic [7:0]                      o_rx_data_value,
    output logic [2:0]                      o_active_mode,
    output logic                            o_resync_request,
    output logic                            o_result_last
);

    localparam int DescW = $bits(sulf_pkg::t_desc);

    logic            push, pop, q_full, q_empty;
    sulf_pkg::t_desc push_desc, head_desc;
    logic [DescW-1:0] head_bits;
    sulf_pkg::t_beat beat;

    sulf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_tx_size_code (i_tx_size_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    sulf_queue #(
        .WIDTH(DescW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_desc),
        .i_pop   (pop),
        .o_rdata (head_bits),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_desc = sulf_pkg::t_desc'(head_bits);

    sulf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_desc    (head_desc),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_beat    (beat)
    );

    assign o_tx_valid       = beat.tx_valid;
    assign o_tx_byte        = beat.tx_byte;
    assign o_tx_frame_end   = beat.tx_frame_end;
    assign o_rx_data_valid  = beat.rx_data_valid;
    assign o_rx_data_index  = beat.rx_data_index;
    assign o_rx_data_value  = beat.rx_data_value;
    assign o_active_mode    = beat.active_mode;
    assign o_resync_request = beat.resync_request;
    assign o_result_last    = beat.result_last;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("work queue overflow");

    a_frame_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_frame_end |-> o_tx_valid && o_result_last)
        else $error("frame checksum beat not last of its item");

    a_rx_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rx_data_valid |-> !o_tx_valid && o_result_last)
        else $error("host payload beat mixed with transmit beat");

endmodule

// ----- rtl/sulf_front.sv -----
module sulf_front #(
    parameter int MAX_PAYLOAD = sulf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_data_byte,
    input  logic [2:0]                          i_tx_size_code,
    input  logic                                i_cfg_we,
    input  logic [sulf_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [sulf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_q_full,
    output logic                                o_push,
    output sulf_pkg::t_desc                     o_desc
);

    localparam int LenW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [2:0] MaxCode = 3'(LenW - 1);
    localparam logic [7:0] MaxSize = 8'(MAX_PAYLOAD);

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_SEL_MODE  = 8'b0000_0010,
        PH_SEL_CHECK = 8'b0000_0100,
        PH_EXT_VALUE = 8'b0000_1000,
        PH_EXT_CHECK = 8'b0001_0000,
        PH_DATA_HDR  = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_PAY_CHECK = 8'b1000_0000
    } t_rx_phase;

    logic [3:0]  r_mode_count;
    logic [15:0] r_hb_limit;
    logic [5:0]  r_exp_size;

    t_rx_phase       r_phase, n_phase;
    logic [7:0]      r_rx_chk, n_rx_chk;
    logic [7:0]      r_pend, n_pend;
    logic [LenW-1:0] r_rem, n_rem;
    logic [4:0]      r_pos, n_pos;
    logic [2:0]      r_mode, n_mode;
    logic [15:0]     r_ticks, n_ticks;
    logic            r_in_frame, n_in_frame;
    logic [LenW-1:0] r_left, n_left;
    logic [7:0]      r_tx_chk, n_tx_chk;

    logic            accept;
    logic [7:0]      b;
    logic [7:0]      size;
    logic [LenW-1:0] rem_dec;
    logic [15:0]     t_inc;
    logic [2:0]      code_sat;
    logic [7:0]      hdr;
    logic [LenW-1:0] left_cur, left_dec;
    logic [7:0]      chk_cur;
    sulf_pkg::t_desc desc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;
    assign o_desc  = desc;
    assign b       = i_data_byte;

    always_comb begin
        n_phase    = r_phase;
        n_rx_chk   = r_rx_chk;
        n_pend     = r_pend;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_ticks    = r_ticks;
        n_in_frame = r_in_frame;
        n_left     = r_left;
        n_tx_chk   = r_tx_chk;
        desc       = '0;

        size     = 8'd1 << b[5:3];
        rem_dec  = r_rem - LenW'(1);
        t_inc    = (r_ticks != 16'hffff) ? r_ticks + 16'd1 : r_ticks;
        code_sat = (i_tx_size_code > MaxCode) ? MaxCode : i_tx_size_code;
        hdr      = {2'b11, code_sat, r_mode};
        left_cur = r_in_frame ? r_left : (LenW'(1) << code_sat);
        chk_cur  = r_in_frame ? r_tx_chk : (sulf_pkg::CHECK_SEED ^ hdr);
        left_dec = left_cur - LenW'(1);

        if (i_kind == sulf_pkg::KIND_RX) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (b == sulf_pkg::LINK_NACK) begin
                        n_ticks = '0;
                    end else if (b == sulf_pkg::LINK_SELECT) begin
                        n_rx_chk = sulf_pkg::CHECK_SEED ^ b;
                        n_phase  = PH_SEL_MODE;
                    end else if ((b & sulf_pkg::MASK_KIND) == sulf_pkg::MSG_CMD
                                 && (b & sulf_pkg::MASK_MODE) == sulf_pkg::EXT_MODE) begin
                        n_phase = PH_EXT_VALUE;
                    end
                end
                PH_SEL_MODE: begin
                    n_pend   = b;
                    n_rx_chk = r_rx_chk ^ b;
                    n_phase  = PH_SEL_CHECK;
                end
                PH_SEL_CHECK: begin
                    if (b == r_rx_chk && r_pend < {4'd0, r_mode_count} && r_pend < 8'd8) begin
                        n_mode = r_pend[2:0];
                    end
                    n_phase = PH_IDLE;
                end
                PH_EXT_VALUE: n_phase = PH_EXT_CHECK;
                PH_EXT_CHECK: n_phase = PH_DATA_HDR;
                PH_DATA_HDR: begin
                    n_phase = PH_IDLE;
                    if ((b & sulf_pkg::MASK_KIND) == sulf_pkg::MSG_DATA
                        && size == {2'd0, r_exp_size} && size <= MaxSize
                        && b[2:0] == r_mode) begin
                        n_rem   = size[LenW-1:0];
                        n_pos   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    desc.rx_valid = 1'b1;
                    desc.rx_idx   = r_pos;
                    desc.data     = b;
                    n_pos         = r_pos + 5'd1;
                    n_rem         = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_PAY_CHECK;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end else if (i_kind == sulf_pkg::KIND_TX) begin
            desc.tx      = 1'b1;
            desc.has_hdr = !r_in_frame;
            desc.hdr     = hdr;
            desc.data    = b;
            desc.has_chk = (left_dec == '0);
            desc.chk     = chk_cur ^ b;
            n_tx_chk     = chk_cur ^ b;
            n_left       = left_dec;
            n_in_frame   = (left_dec != '0);
        end else if (i_kind == sulf_pkg::KIND_TICK) begin
            if (t_inc > r_hb_limit) begin
                desc.resync = 1'b1;
                n_ticks     = '0;
                n_phase     = PH_IDLE;
            end else begin
                n_ticks = t_inc;
            end
        end
        desc.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rx_chk   <= '0;
            r_pend     <= '0;
            r_rem      <= '0;
            r_pos      <= '0;
            r_mode     <= '0;
            r_ticks    <= '0;
            r_in_frame <= 1'b0;
            r_left     <= '0;
            r_tx_chk   <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_rx_chk   <= n_rx_chk;
            r_pend     <= n_pend;
            r_rem      <= n_rem;
            r_pos      <= n_pos;
            r_mode     <= n_mode;
            r_ticks    <= n_ticks;
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_tx_chk   <= n_tx_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count <= sulf_pkg::MODE_COUNT_RST;
            r_hb_limit   <= sulf_pkg::HB_LIMIT_RST;
            r_exp_size   <= sulf_pkg::EXP_SIZE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == sulf_pkg::CFG_MODE_COUNT) begin
                r_mode_count <= i_cfg_wdata[3:0];
            end
            if (i_cfg_addr == sulf_pkg::CFG_HEARTBEAT_LIMIT) begin
                r_hb_limit <= i_cfg_wdata[15:0];
            end
            if (i_cfg_addr == sulf_pkg::CFG_EXPECTED_SIZE) begin
                r_exp_size <= i_cfg_wdata[5:0];
            end
        end
    end

endmodule

// ----- rtl/sulf_queue.sv -----
module sulf_queue #(
    parameter int WIDTH = $bits(sulf_pkg::t_desc),
    parameter int DEPTH = sulf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

// ----- rtl/sulf_back.sv -----
module sulf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sulf_pkg::t_desc i_desc,
    input  logic            i_q_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output sulf_pkg::t_beat o_beat
);

    localparam logic [1:0] BEAT_HDR  = 2'd0;
    localparam logic [1:0] BEAT_DATA = 2'd1;
    localparam logic [1:0] BEAT_CHK  = 2'd2;

    logic            r_started;
    logic [1:0]      r_beat;
    logic            r_ov;
    sulf_pkg::t_beat r_out;

    logic            take, fire, last;
    logic [1:0]      beat_sel;
    sulf_pkg::t_beat beat;

    assign take = !r_ov || i_ready;
    assign fire = take && !i_q_empty;

    always_comb begin
        if (r_started) begin
            beat_sel = r_beat;
        end else if (i_desc.tx && i_desc.has_hdr) begin
            beat_sel = BEAT_HDR;
        end else begin
            beat_sel = BEAT_DATA;
        end
        last = (beat_sel == BEAT_CHK)
               || (beat_sel == BEAT_DATA && !(i_desc.tx && i_desc.has_chk));

        beat.tx_valid       = i_desc.tx;
        beat.tx_byte        = '0;
        if (i_desc.tx) begin
            unique case (beat_sel)
                BEAT_HDR: beat.tx_byte = i_desc.hdr;
                BEAT_CHK: beat.tx_byte = i_desc.chk;
                default:  beat.tx_byte = i_desc.data;
            endcase
        end
        beat.tx_frame_end   = (beat_sel == BEAT_CHK);
        beat.rx_data_valid  = i_desc.rx_valid;
        beat.rx_data_index  = i_desc.rx_idx;
        beat.rx_data_value  = i_desc.tx ? 8'd0 : i_desc.data;
        beat.active_mode    = i_desc.mode;
        beat.resync_request = i_desc.resync;
        beat.result_last    = last;
    end

    assign o_pop   = fire && last;
    assign o_valid = r_ov;
    assign o_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_started <= 1'b0;
            r_beat    <= BEAT_HDR;
        end else begin
            if (take) begin
                r_ov <= !i_q_empty;
            end
            if (fire) begin
                r_started <= !last;
                r_beat    <= (beat_sel == BEAT_HDR) ? BEAT_DATA : BEAT_CHK;
            end
        end
    end

endmodule
